// ===== rtl/core/sct_pkg.sv =====
// ----------------------------------------------------------------------------
// Shape collision test package
// Shared widths, payload types, command codes and sign-extension helpers
// for the 2-D shape collision test pipeline.
// ----------------------------------------------------------------------------
package sct_pkg;

	// Coordinate width and the widths that grow out of it.
	localparam int COORD_WIDTH = 16;
	localparam int SUM_WIDTH   = COORD_WIDTH + 1;
	localparam int DIFF_WIDTH  = COORD_WIDTH + 2;
	localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
	localparam int CROSS_WIDTH = PROD_WIDTH + 1;

	// A box's edges are each tested against the segment; NUM_EDGES gives their number.
	localparam int NUM_EDGES = 4;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [SUM_WIDTH-1:0]   sum_t;
	typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
	typedef logic signed [PROD_WIDTH-1:0]  prod_t;
	typedef logic signed [CROSS_WIDTH-1:0] cross_t;

	// Pair test selected by the command field.
	typedef enum logic [2:0] {
		CMD_PT_PT     = 3'd0,
		CMD_PT_CIRC   = 3'd1,
		CMD_PT_BOX    = 3'd2,
		CMD_SEG_SEG   = 3'd3,
		CMD_SEG_BOX   = 3'd4,
		CMD_CIRC_CIRC = 3'd5,
		CMD_CIRC_BOX  = 3'd6,
		CMD_BOX_BOX   = 3'd7
	} cmd_t;

	// One input word as held in the first pipeline stage.
	typedef struct packed {
		cmd_t   command;
		coord_t a_x;
		coord_t a_y;
		coord_t a_u;
		coord_t a_v;
		coord_t b_x;
		coord_t b_y;
		coord_t b_u;
		coord_t b_v;
	} shapes_t;

	// Single-bit results that need no multiplier, carried down the pipe with the command.
	typedef struct packed {
		cmd_t command;
		logic pt_equal;
		logic a_in_box;
		logic u_in_box;
		logic box_overlap;
		logic radius_ok;
	} flags_t;

	// Operands of one segment-against-segment test. The first segment's
	// direction is shared and travels separately.
	typedef struct packed {
		diff_t ex2;
		diff_t ey2;
		diff_t dx;
		diff_t dy;
	} seg_ops_t;

	// Operands of the squared-distance test.
	typedef struct packed {
		diff_t dx;
		diff_t dy;
		sum_t  r;
	} dist_ops_t;

	// Load enables for the product and sum stages of the arithmetic units.
	typedef struct packed {
		logic en_s3;
		logic en_s4;
	} adv_t;

	function automatic sum_t ext_sum(input coord_t v);
		return {v[COORD_WIDTH-1], v};
	endfunction

	function automatic diff_t ext_diff(input coord_t v);
		return {{(DIFF_WIDTH-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
	endfunction

	function automatic diff_t sum_to_diff(input sum_t v);
		return {{(DIFF_WIDTH-SUM_WIDTH){v[SUM_WIDTH-1]}}, v};
	endfunction

	function automatic cross_t ext_prod(input prod_t v);
		return {v[PROD_WIDTH-1], v};
	endfunction

endpackage

// ===== rtl/core/sct_if.sv =====
// ----------------------------------------------------------------------------
// Shape collision test channels
// Valid/ready channels for the shape pair words and for the hit words.
// ----------------------------------------------------------------------------
interface sct_in_if;
	logic               valid;
	logic               ready;
	sct_pkg::cmd_t      command;
	sct_pkg::coord_t    a_x;
	sct_pkg::coord_t    a_y;
	sct_pkg::coord_t    a_u;
	sct_pkg::coord_t    a_v;
	sct_pkg::coord_t    b_x;
	sct_pkg::coord_t    b_y;
	sct_pkg::coord_t    b_u;
	sct_pkg::coord_t    b_v;

	modport source (
		output valid, command, a_x, a_y, a_u, a_v, b_x, b_y, b_u, b_v,
		input  ready
	);
	modport sink (
		input  valid, command, a_x, a_y, a_u, a_v, b_x, b_y, b_u, b_v,
		output ready
	);
endinterface

interface sct_out_if;
	logic valid;
	logic ready;
	logic hit;

	modport source (
		output valid, hit,
		input  ready
	);
	modport sink (
		input  valid, hit,
		output ready
	);
endinterface

// ===== rtl/core/sct_prep.sv =====
// ----------------------------------------------------------------------------
// Shape collision test operand preparation
// Forms box edges, differences and clamped offsets from one shape pair and
// evaluates the compare-only tests.
// ----------------------------------------------------------------------------
module sct_prep (
	input  sct_pkg::shapes_t   shapes,
	output sct_pkg::flags_t    flags,
	output sct_pkg::diff_t     ex1,
	output sct_pkg::diff_t     ey1,
	output sct_pkg::seg_ops_t  seg_ops [sct_pkg::NUM_EDGES],
	output sct_pkg::dist_ops_t dist_ops
);
	import sct_pkg::*;

	sum_t  ax_s, ay_s, au_s, av_s, bx_s, by_s, bu_s, bv_s;
	sum_t  rx_s, ry_s, axu_s, ayv_s;
	diff_t ax_d, ay_d, au_d, av_d, bx_d, by_d, bu_d, bv_d, rx_d, ry_d;
	diff_t dxb, dyb, dxr, dyr, cdx, cdy;
	logic  is_seg_seg;

	// Sign-extended coordinates and the far box corner.
	always_comb begin
		ax_s  = ext_sum(shapes.a_x);
		ay_s  = ext_sum(shapes.a_y);
		au_s  = ext_sum(shapes.a_u);
		av_s  = ext_sum(shapes.a_v);
		bx_s  = ext_sum(shapes.b_x);
		by_s  = ext_sum(shapes.b_y);
		bu_s  = ext_sum(shapes.b_u);
		bv_s  = ext_sum(shapes.b_v);
		rx_s  = bx_s + bu_s;
		ry_s  = by_s + bv_s;
		axu_s = ax_s + au_s;
		ayv_s = ay_s + av_s;
	end

	always_comb begin
		ax_d = ext_diff(shapes.a_x);
		ay_d = ext_diff(shapes.a_y);
		au_d = ext_diff(shapes.a_u);
		av_d = ext_diff(shapes.a_v);
		bx_d = ext_diff(shapes.b_x);
		by_d = ext_diff(shapes.b_y);
		bu_d = ext_diff(shapes.b_u);
		bv_d = ext_diff(shapes.b_v);
		rx_d = sum_to_diff(rx_s);
		ry_d = sum_to_diff(ry_s);
		dxb  = ax_d - bx_d;
		dyb  = ay_d - by_d;
		dxr  = ax_d - rx_d;
		dyr  = ay_d - ry_d;
	end

	// Offset from the circle centre to the nearest point of the box.
	always_comb begin
		if (ax_s < bx_s) begin
			cdx = dxb;
		end else if (ax_s > rx_s) begin
			cdx = dxr;
		end else begin
			cdx = '0;
		end
		if (ay_s < by_s) begin
			cdy = dyb;
		end else if (ay_s > ry_s) begin
			cdy = dyr;
		end else begin
			cdy = '0;
		end
	end

	// Distance operands for the three circle tests.
	always_comb begin
		case (shapes.command)
			CMD_CIRC_CIRC: begin
				dist_ops.dx = dxb;
				dist_ops.dy = dyb;
				dist_ops.r  = au_s + bu_s;
			end
			CMD_CIRC_BOX: begin
				dist_ops.dx = cdx;
				dist_ops.dy = cdy;
				dist_ops.r  = au_s;
			end
			default: begin
				dist_ops.dx = dxb;
				dist_ops.dy = dyb;
				dist_ops.r  = bu_s;
			end
		endcase
	end

	// Segment operands. The first unit serves the plain segment pair test
	// or the left box edge; the others take the right, bottom and top edges.
	assign is_seg_seg = (shapes.command == CMD_SEG_SEG);
	assign ex1        = au_d - ax_d;
	assign ey1        = av_d - ay_d;

	always_comb begin
		seg_ops[0].ex2 = is_seg_seg ? (bu_d - bx_d) : '0;
		seg_ops[0].ey2 = is_seg_seg ? (bv_d - by_d) : bv_d;
		seg_ops[0].dx  = dxb;
		seg_ops[0].dy  = dyb;
		seg_ops[1].ex2 = '0;
		seg_ops[1].ey2 = bv_d;
		seg_ops[1].dx  = dxr;
		seg_ops[1].dy  = dyb;
		seg_ops[2].ex2 = bu_d;
		seg_ops[2].ey2 = '0;
		seg_ops[2].dx  = dxb;
		seg_ops[2].dy  = dyb;
		seg_ops[3].ex2 = bu_d;
		seg_ops[3].ey2 = '0;
		seg_ops[3].dx  = dxb;
		seg_ops[3].dy  = dyr;
	end

	// Compare-only tests.
	always_comb begin
		flags.command     = shapes.command;
		flags.pt_equal    = (shapes.a_x == shapes.b_x) && (shapes.a_y == shapes.b_y);
		flags.a_in_box    = (ax_s >= bx_s) && (ax_s <= rx_s) &&
		                    (ay_s >= by_s) && (ay_s <= ry_s);
		flags.u_in_box    = (au_s >= bx_s) && (au_s <= rx_s) &&
		                    (av_s >= by_s) && (av_s <= ry_s);
		flags.box_overlap = (axu_s >= bx_s) && (ax_s <= rx_s) &&
		                    (ayv_s >= by_s) && (ay_s <= ry_s);
		flags.radius_ok   = !dist_ops.r[SUM_WIDTH-1];
	end

endmodule

// ===== rtl/core/sct_cross.sv =====
// ----------------------------------------------------------------------------
// Shape collision test segment crossing unit
// Pipelined cross-product test of one segment pair: products, then the
// denominator and both numerators, then the sign compares.
// ----------------------------------------------------------------------------
module sct_cross (
	input  logic              clk,
	input  sct_pkg::adv_t     adv,
	input  sct_pkg::diff_t    ex1,
	input  sct_pkg::diff_t    ey1,
	input  sct_pkg::seg_ops_t ops,
	output logic              hit
);
	import sct_pkg::*;

	diff_t  ex2, ey2, dx, dy;
	prod_t  p_den1_s3, p_den2_s3, p_na1_s3, p_na2_s3, p_nb1_s3, p_nb2_s3;
	cross_t den_s4, na_s4, nb_s4;
	logic   den_pos, den_neg;

	assign ex2 = ops.ex2;
	assign ey2 = ops.ey2;
	assign dx  = ops.dx;
	assign dy  = ops.dy;

	// Six partial products of the three cross terms.
	always_ff @(posedge clk) begin
		if (adv.en_s3) begin
			p_den1_s3 <= ey2 * ex1;
			p_den2_s3 <= ex2 * ey1;
			p_na1_s3  <= ex2 * dy;
			p_na2_s3  <= ey2 * dx;
			p_nb1_s3  <= ex1 * dy;
			p_nb2_s3  <= ey1 * dx;
		end
	end

	// Denominator and the two numerators.
	always_ff @(posedge clk) begin
		if (adv.en_s4) begin
			den_s4 <= ext_prod(p_den1_s3) - ext_prod(p_den2_s3);
			na_s4  <= ext_prod(p_na1_s3) - ext_prod(p_na2_s3);
			nb_s4  <= ext_prod(p_nb1_s3) - ext_prod(p_nb2_s3);
		end
	end

	// Both parameters must lie between zero and the denominator; parallel
	// segments never cross.
	assign den_neg = den_s4[CROSS_WIDTH-1];
	assign den_pos = !den_neg && (den_s4 != '0);

	always_comb begin
		if (den_pos) begin
			hit = !na_s4[CROSS_WIDTH-1] && (na_s4 <= den_s4) &&
			      !nb_s4[CROSS_WIDTH-1] && (nb_s4 <= den_s4);
		end else if (den_neg) begin
			hit = (na_s4[CROSS_WIDTH-1] || (na_s4 == '0)) && (na_s4 >= den_s4) &&
			      (nb_s4[CROSS_WIDTH-1] || (nb_s4 == '0)) && (nb_s4 >= den_s4);
		end else begin
			hit = 1'b0;
		end
	end

endmodule

// ===== rtl/core/sct_dist.sv =====
// ----------------------------------------------------------------------------
// Shape collision test distance unit
// Pipelined squared-distance compare: squares, then their sum, then the
// compare against the squared radius.
// ----------------------------------------------------------------------------
module sct_dist (
	input  logic               clk,
	input  sct_pkg::adv_t      adv,
	input  sct_pkg::dist_ops_t ops,
	output logic               hit
);
	import sct_pkg::*;

	diff_t  dx, dy;
	sum_t   r;
	prod_t  pdx_s3, pdy_s3, prr_s3, prr_s4;
	cross_t sq_s4;

	assign dx = ops.dx;
	assign dy = ops.dy;
	assign r  = ops.r;

	// Squares of both offsets and of the radius.
	always_ff @(posedge clk) begin
		if (adv.en_s3) begin
			pdx_s3 <= dx * dx;
			pdy_s3 <= dy * dy;
			prr_s3 <= r * r;
		end
	end

	// Squared distance.
	always_ff @(posedge clk) begin
		if (adv.en_s4) begin
			sq_s4  <= ext_prod(pdx_s3) + ext_prod(pdy_s3);
			prr_s4 <= prr_s3;
		end
	end

	// Touching counts as a hit.
	assign hit = (sq_s4 <= ext_prod(prr_s4));

endmodule

// ===== rtl/core/shape_collision_test_unit.sv =====
// ----------------------------------------------------------------------------
// Shape collision test unit
// Stateless 2-D narrow-phase test of one shape pair per word.
// ----------------------------------------------------------------------------
// One shape pair word is accepted every clock cycle while the pipe is not
// stalled, and each pair yields one hit word. A pair passes through an
// input register, an operand stage (box edges, differences, clamped offsets
// and the compare-only tests), a product stage, a stage that combines
// products into the cross terms and squared distance, and the result
// register that holds the selected hit. Each stage holds its word while the
// one after it is full, so back-pressure on the result channel stalls the
// pipe without losing or repeating words. Reset clears only the pipe's
// valid bits.
// ----------------------------------------------------------------------------
module shape_collision_test_unit (
	input  logic      clk,
	input  logic      arst_n,
	sct_in_if.sink    shapes,
	sct_out_if.source result
);
	import sct_pkg::*;

	shapes_t   in_s1;
	flags_t    flags_d, flags_s2, flags_s3, flags_s4;
	diff_t     ex1_d, ey1_d, ex1_s2, ey1_s2;
	seg_ops_t  seg_d  [NUM_EDGES];
	seg_ops_t  seg_s2 [NUM_EDGES];
	dist_ops_t dist_d, dist_s2;
	adv_t      adv;
	logic      [NUM_EDGES-1:0] edge_hit;
	logic      dist_hit;
	logic      hit_d;
	logic      hit_q, ov_q;
	logic      v_s1, v_s2, v_s3, v_s4;
	logic      rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_out;

	// Each stage takes a new word when it is empty or its word moves on.
	assign rdy_out      = !ov_q || result.ready;
	assign rdy_s4       = !v_s4 || rdy_out;
	assign rdy_s3       = !v_s3 || rdy_s4;
	assign rdy_s2       = !v_s2 || rdy_s3;
	assign rdy_s1       = !v_s1 || rdy_s2;
	assign shapes.ready = rdy_s1;
	assign adv.en_s3    = rdy_s3;
	assign adv.en_s4    = rdy_s4;

	// Valid bits of the pipe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= shapes.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_out) ov_q <= v_s4;
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			in_s1 <= '{
				command: shapes.command,
				a_x:     shapes.a_x,
				a_y:     shapes.a_y,
				a_u:     shapes.a_u,
				a_v:     shapes.a_v,
				b_x:     shapes.b_x,
				b_y:     shapes.b_y,
				b_u:     shapes.b_u,
				b_v:     shapes.b_v
			};
		end
	end

	sct_prep u_prep (
		.shapes   (in_s1),
		.flags    (flags_d),
		.ex1      (ex1_d),
		.ey1      (ey1_d),
		.seg_ops  (seg_d),
		.dist_ops (dist_d)
	);

	// Operand register.
	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			flags_s2 <= flags_d;
			ex1_s2   <= ex1_d;
			ey1_s2   <= ey1_d;
			seg_s2   <= seg_d;
			dist_s2  <= dist_d;
		end
	end

	// Compare-only results follow the arithmetic units down the pipe.
	always_ff @(posedge clk) begin
		if (rdy_s3) flags_s3 <= flags_s2;
		if (rdy_s4) flags_s4 <= flags_s3;
	end

	for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge
		sct_cross u_cross (
			.clk (clk),
			.adv (adv),
			.ex1 (ex1_s2),
			.ey1 (ey1_s2),
			.ops (seg_s2[e]),
			.hit (edge_hit[e])
		);
	end

	sct_dist u_dist (
		.clk (clk),
		.adv (adv),
		.ops (dist_s2),
		.hit (dist_hit)
	);

	// Pick the hit of the commanded test.
	always_comb begin
		hit_d = 1'b0;
		case (flags_s4.command)
			CMD_PT_PT:     hit_d = flags_s4.pt_equal;
			CMD_PT_CIRC:   hit_d = flags_s4.radius_ok && dist_hit;
			CMD_PT_BOX:    hit_d = flags_s4.a_in_box;
			CMD_SEG_SEG:   hit_d = edge_hit[0];
			CMD_SEG_BOX:   hit_d = (flags_s4.a_in_box && flags_s4.u_in_box) ||
			                       (|edge_hit);
			CMD_CIRC_CIRC: hit_d = flags_s4.radius_ok && dist_hit;
			CMD_CIRC_BOX:  hit_d = flags_s4.radius_ok && dist_hit;
			CMD_BOX_BOX:   hit_d = flags_s4.box_overlap;
			default:       hit_d = 1'b0;
		endcase
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (rdy_out) hit_q <= hit_d;
	end

	assign result.valid = ov_q;
	assign result.hit   = hit_q;

endmodule
